>>> hdl/spq_pkg.sv
// shared types and constants for the stable sorted priority queue
// no dependencies

package spq_pkg;

   localparam int DEFAULT_DEPTH = 128;
   localparam int PRIO_W        = 8;
   localparam int PAYLOAD_W     = 16;
   localparam int OCC_W         = 8;
   localparam int STATUS_W      = 2;

   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_SHIFT_OUT
   } cell_op_type;

   typedef struct packed {
      logic [PRIO_W-1:0]    prio;
      logic [PAYLOAD_W-1:0] payload;
   } entry_type;

   typedef struct packed {
      cell_op_type op;
      entry_type   fresh;
   } cell_cmd_type;

endpackage

>>> hdl/spq_req_if.sv
// request channel: valid/ready handshake with one queue operation per word
// depends on spq_pkg

interface spq_req_if import spq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 mode;
   logic [PRIO_W-1:0]    priority_req;
   logic [PAYLOAD_W-1:0] payload;

   modport source (output valid, mode, priority_req, payload, input ready);
   modport sink   (input valid, mode, priority_req, payload, output ready);
endinterface

>>> hdl/spq_rsp_if.sv
// response channel: valid/ready handshake with one result word per request
// depends on spq_pkg

interface spq_rsp_if import spq_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STATUS_W-1:0]  status;
   logic [PRIO_W-1:0]    head_priority;
   logic [PAYLOAD_W-1:0] head_payload;
   logic [OCC_W-1:0]     occupancy;

   modport source (output valid, status, head_priority, head_payload, occupancy,
                   input ready);
   modport sink   (input valid, status, head_priority, head_payload, occupancy,
                   output ready);
endinterface

>>> hdl/spq_cell.sv
// one slot of the sorted shift chain: holds an entry, inserts or shifts toward the head
// depends on spq_pkg

module spq_cell import spq_pkg::*; (
   input  logic         clock,
   input  cell_cmd_type cmd,
   input  logic         live,
   input  logic         left_ge,
   input  entry_type    left_entry,
   input  entry_type    right_entry,
   output entry_type    entry,
   output logic         ge
);

   entry_type entry_ff;
   entry_type entry_in;

   assign ge    = live && (entry_ff.prio >= cmd.fresh.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (ge) begin
               entry_in = entry_ff;
            end else if (left_ge) begin
               entry_in = cmd.fresh;
            end else begin
               entry_in = left_entry;
            end
         end
         OP_SHIFT_OUT: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

>>> hdl/stable_sorted_priority_queue.sv
// top level: request decode, entry count, chain of sorted cells and response register
// depends on spq_pkg, spq_req_if, spq_rsp_if, spq_cell
//
//   channel    dir   fields
//   req_chan   in    mode, priority_req, payload
//   rsp_chan   out   status, head_priority, head_payload, occupancy
//
// one request word is taken per cycle while the response register is empty or
// being drained; its response appears on the next cycle. every cell moves in the
// same cycle, so insert and head removal each take the same time whatever the depth.
// reset clears the count and the response valid only; no clearing pass.
// a stalled response holds the request side off until it is taken.

module stable_sorted_priority_queue import spq_pkg::*; #(
   parameter int DEPTH = DEFAULT_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   status_type           status_ff;
   status_type           status_in;
   entry_type            head_ff;
   entry_type            head_in;
   logic [OCC_W-1:0]     occ_ff;
   logic [OCC_W-1:0]     occ_in;

   logic                 fire;
   logic                 full;
   logic                 empty;
   cell_cmd_type         cmd;
   entry_type            cell_entry [DEPTH];
   logic [DEPTH-1:0]     cell_ge;
   logic [DEPTH-1:0]     cell_live;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire  = req_chan.valid && req_chan.ready;
   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      cmd.op            = OP_HOLD;
      cmd.fresh.prio    = req_chan.priority_req;
      cmd.fresh.payload = req_chan.payload;
      count_in  = count_ff;
      status_in = status_ff;
      head_in   = head_ff;
      if (fire) begin
         head_in = '0;
         unique case (req_chan.mode)
            MODE_ENQUEUE: begin
               if (full) begin
                  status_in = STATUS_FULL;
               end else begin
                  status_in = STATUS_DONE;
                  cmd.op    = OP_INSERT;
                  count_in  = count_ff + CNT_W'(1);
               end
            end
            MODE_DEQUEUE: begin
               if (empty) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  status_in = STATUS_DONE;
                  cmd.op    = OP_SHIFT_OUT;
                  head_in   = cell_entry[0];
                  count_in  = count_ff - CNT_W'(1);
               end
            end
            default: begin
               status_in = STATUS_DONE;
            end
         endcase
      end
   end

   always_comb begin
      occ_in       = fire ? OCC_W'(count_in) : occ_ff;
      rsp_valid_in = fire || (rsp_valid_ff && !rsp_chan.ready);
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         entry_type left_entry;
         entry_type right_entry;
         logic      left_ge;

         assign cell_live[i] = (count_ff > CNT_W'(i));

         if (i == 0) begin : g_head
            assign left_ge    = 1'b1;
            assign left_entry = cmd.fresh;
         end else begin : g_body
            assign left_ge    = cell_ge[i-1];
            assign left_entry = cell_entry[i-1];
         end

         if (i == DEPTH - 1) begin : g_tail
            assign right_entry = cell_entry[i];
         end else begin : g_inner
            assign right_entry = cell_entry[i+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .live        (cell_live[i]),
            .left_ge     (left_ge),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .entry       (cell_entry[i]),
            .ge          (cell_ge[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      head_ff   <= head_in;
      occ_ff    <= occ_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.head_priority = head_ff.prio;
   assign rsp_chan.head_payload  = head_ff.payload;
   assign rsp_chan.occupancy     = occ_ff;

endmodule

>>> tb/tb.sv
// testbench for stable_sorted_priority_queue: a directed table of words, then biased random
// traffic that fills, holds, drains and idles the queue, checked by a sorted-queue predictor
// depends on spq_pkg, spq_req_if, spq_rsp_if and stable_sorted_priority_queue

module tb;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH  = DEFAULT_DEPTH;
   localparam int RANDOM_WORDS = 1330;
   localparam int MAX_REPORTS  = 10;

   typedef struct packed {
      status_type           status;
      logic [PRIO_W-1:0]    head_prio;
      logic [PAYLOAD_W-1:0] head_tag;
      logic [OCC_W-1:0]     occ;
   } queue_result_type;

   typedef struct packed {
      logic                 mode;
      logic [PRIO_W-1:0]    prio;
      logic [PAYLOAD_W-1:0] tag;
      logic                 typed;
      queue_result_type     result;
   } directed_row_type;

   // typed rows carry their result, the rest go through the predictor
   localparam directed_row_type DIRECTED_ROWS [20] = '{
      '{MODE_DEQUEUE, 8'd0,   16'h0000, 1'b1, '{STATUS_EMPTY, 8'd0,   16'h0000, 8'd0}},
      '{MODE_ENQUEUE, 8'd255, 16'hffff, 1'b1, '{STATUS_DONE,  8'd0,   16'h0000, 8'd1}},
      '{MODE_DEQUEUE, 8'd0,   16'h0000, 1'b1, '{STATUS_DONE,  8'd255, 16'hffff, 8'd0}},
      '{MODE_ENQUEUE, 8'd0,   16'h0000, 1'b1, '{STATUS_DONE,  8'd0,   16'h0000, 8'd1}},
      '{MODE_ENQUEUE, 8'd0,   16'h0001, 1'b1, '{STATUS_DONE,  8'd0,   16'h0000, 8'd2}},
      '{MODE_ENQUEUE, 8'd0,   16'h0002, 1'b1, '{STATUS_DONE,  8'd0,   16'h0000, 8'd3}},
      '{MODE_ENQUEUE, 8'd128, 16'h8000, 1'b1, '{STATUS_DONE,  8'd0,   16'h0000, 8'd4}},
      '{MODE_ENQUEUE, 8'd1,   16'h00ff, 1'b1, '{STATUS_DONE,  8'd0,   16'h0000, 8'd5}},
      '{MODE_ENQUEUE, 8'd128, 16'h7fff, 1'b1, '{STATUS_DONE,  8'd0,   16'h0000, 8'd6}},
      '{MODE_ENQUEUE, 8'd255, 16'haaaa, 1'b1, '{STATUS_DONE,  8'd0,   16'h0000, 8'd7}},
      '{MODE_ENQUEUE, 8'd127, 16'h5555, 1'b1, '{STATUS_DONE,  8'd0,   16'h0000, 8'd8}},
      '{MODE_DEQUEUE, 8'd0,   16'h0000, 1'b0, '{STATUS_DONE,  8'd0,   16'h0000, 8'd0}},
      '{MODE_DEQUEUE, 8'd17,  16'h1234, 1'b0, '{STATUS_DONE,  8'd0,   16'h0000, 8'd0}},
      '{MODE_DEQUEUE, 8'd0,   16'h0000, 1'b0, '{STATUS_DONE,  8'd0,   16'h0000, 8'd0}},
      '{MODE_DEQUEUE, 8'd0,   16'h0000, 1'b0, '{STATUS_DONE,  8'd0,   16'h0000, 8'd0}},
      '{MODE_DEQUEUE, 8'd0,   16'h0000, 1'b0, '{STATUS_DONE,  8'd0,   16'h0000, 8'd0}},
      '{MODE_DEQUEUE, 8'd0,   16'h0000, 1'b0, '{STATUS_DONE,  8'd0,   16'h0000, 8'd0}},
      '{MODE_DEQUEUE, 8'd0,   16'h0000, 1'b0, '{STATUS_DONE,  8'd0,   16'h0000, 8'd0}},
      '{MODE_DEQUEUE, 8'd0,   16'h0000, 1'b0, '{STATUS_DONE,  8'd0,   16'h0000, 8'd0}},
      '{MODE_DEQUEUE, 8'd255, 16'hffff, 1'b1, '{STATUS_EMPTY, 8'd0,   16'h0000, 8'd0}}
   };

   logic clock;
   logic reset;

   spq_req_if req_if ();
   spq_rsp_if rsp_if ();

   stable_sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   logic [PRIO_W-1:0]    held_prio [QUEUE_DEPTH];
   logic [PAYLOAD_W-1:0] held_tag  [QUEUE_DEPTH];
   int                   held_count;

   queue_result_type pending_results [$];
   int               fail_count;
   int               sent_count;
   bit               send_quiet;
   bit               recv_quiet;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic queue_result_type apply_word(input logic mode,
                                                   input logic [PRIO_W-1:0] prio,
                                                   input logic [PAYLOAD_W-1:0] tag);
      queue_result_type res;
      int               slot;
      int               k;
      res = '{STATUS_DONE, '0, '0, '0};
      if (mode == MODE_ENQUEUE) begin
         if (held_count >= QUEUE_DEPTH) begin
            res.status = STATUS_FULL;
         end else begin
            // equal priorities stay behind the ones already held
            slot = 0;
            while (slot < held_count && held_prio[slot] >= prio) slot++;
            for (k = held_count; k > slot; k--) begin
               held_prio[k] = held_prio[k-1];
               held_tag[k]  = held_tag[k-1];
            end
            held_prio[slot] = prio;
            held_tag[slot]  = tag;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.head_prio = held_prio[0];
            res.head_tag  = held_tag[0];
            for (k = 1; k < held_count; k++) begin
               held_prio[k-1] = held_prio[k];
               held_tag[k-1]  = held_tag[k];
            end
            held_count--;
         end
      end
      res.occ = OCC_W'(held_count);
      return res;
   endfunction

   task automatic send_word(input logic mode, input logic [PRIO_W-1:0] prio,
                            input logic [PAYLOAD_W-1:0] tag, input logic typed,
                            input queue_result_type typed_result);
      int               gap;
      queue_result_type want;
      gap = send_quiet ? 0 : $urandom_range(0, 16);
      @(negedge clock);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.mode         <= mode;
      req_if.priority_req <= prio;
      req_if.payload      <= tag;
      do @(posedge clock); while (!req_if.ready);
      want = apply_word(mode, prio, tag);
      pending_results.push_back(typed ? typed_result : want);
      sent_count++;
      if (sent_count % 50 == 0) send_quiet = ($urandom_range(0, 2) == 0);
   endtask

   initial begin
      queue_result_type  unused_result;
      int                enq_pct;
      int                phase_pos;
      logic              mode;
      logic [PRIO_W-1:0] prio;
      reset               = 1'b1;
      req_if.valid        = 1'b0;
      req_if.mode         = MODE_ENQUEUE;
      req_if.priority_req = '0;
      req_if.payload      = '0;
      held_count          = 0;
      fail_count          = 0;
      sent_count          = 0;
      send_quiet          = 1'b0;
      unused_result       = '{STATUS_DONE, '0, '0, '0};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         send_word(DIRECTED_ROWS[i].mode, DIRECTED_ROWS[i].prio, DIRECTED_ROWS[i].tag,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].result);
      end

      // fill to full, hover near full, drain to empty, hover near empty
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         phase_pos = i % 600;
         if (phase_pos < 200) enq_pct = 95;
         else if (phase_pos < 300) enq_pct = 60;
         else if (phase_pos < 500) enq_pct = 5;
         else enq_pct = 40;
         mode = ($urandom_range(0, 99) < enq_pct) ? MODE_ENQUEUE : MODE_DEQUEUE;
         case ($urandom_range(0, 3))
            0: prio = PRIO_W'($urandom_range(0, 3));
            1: prio = $urandom_range(0, 1) ? 8'hff : 8'h00;
            default: prio = PRIO_W'($urandom_range(0, 255));
         endcase
         send_word(mode, prio, PAYLOAD_W'($urandom_range(0, 65535)), 1'b0, unused_result);
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

   initial begin
      int               stall;
      int               taken;
      queue_result_type want;
      rsp_if.ready = 1'b0;
      taken        = 0;
      recv_quiet   = 1'b0;
      do @(negedge clock); while (reset !== 1'b0);
      forever begin
         stall = recv_quiet ? 0 : $urandom_range(0, 16);
         @(negedge clock);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         do @(posedge clock); while (rsp_if.valid !== 1'b1);
         if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
               $display("tb: unexpected word status %0d prio %0d tag %h occ %0d",
                        rsp_if.status, rsp_if.head_priority, rsp_if.head_payload,
                        rsp_if.occupancy);
         end else begin
            want = pending_results.pop_front();
            if (want.status !== rsp_if.status || want.head_prio !== rsp_if.head_priority ||
                want.head_tag !== rsp_if.head_payload || want.occ !== rsp_if.occupancy) begin
               fail_count++;
               if (fail_count <= MAX_REPORTS) begin
                  $write("tb: mismatch want status %0d prio %0d tag %h occ %0d,",
                         want.status, want.head_prio, want.head_tag, want.occ);
                  $display(" got status %0d prio %0d tag %h occ %0d",
                           rsp_if.status, rsp_if.head_priority, rsp_if.head_payload,
                           rsp_if.occupancy);
               end
            end
         end
         taken++;
         if (taken % 50 == 0) recv_quiet = ($urandom_range(0, 2) == 0);
      end
   end

   initial begin
      #4_000_000;
      $display("tb: done, errors");
      $finish;
   end

endmodule
